// ===== src/cmdp_pkg.sv =====
// Package for the motion command text parser: pattern element types, character
// codes, record row layout and the structs passed between parser and record store.
// No dependencies.
`timescale 1ns / 1ps

package cmdp_pkg;

    // Default number of joints in one command, and the largest count that the joint number field is sized for.
    localparam int JOINT_COUNT_DEF = 6;
    localparam int MAX_JOINTS      = 9;

    // Joint number field wide enough for MAX_JOINTS.
    localparam int ROW_W = $clog2(MAX_JOINTS + 1);
    // Offset within one pattern segment (a joint segment is 17 elements long).
    localparam int OFF_W = 5;

    localparam logic [OFF_W-1:0] HEAD_LAST_OFF  = 5'd4;
    localparam logic [OFF_W-1:0] JOINT_LAST_OFF = 5'd16;
    localparam logic [OFF_W-1:0] TAIL_LAST_OFF  = 5'd1;
    localparam logic [OFF_W-1:0] OFF_ANGLE      = 5'd3;
    localparam logic [OFF_W-1:0] OFF_START      = 5'd9;
    localparam logic [OFF_W-1:0] OFF_TARGET     = 5'd15;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG1  = 8'h31;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_V     = 8'h56;

    // Saturation limits of a parsed number.
    localparam logic [31:0] NUM_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] NUM_MAG_MAX = 32'h8000_0000;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_JOINT,
        PH_TAIL,
        PH_END
    } phase_t;

    typedef enum logic [1:0] {
        EK_LIT,
        EK_WS,
        EK_NUM
    } elem_kind_t;

    typedef struct packed {
        elem_kind_t kind;
        logic [7:0] lit;
    } elem_t;

    typedef struct packed {
        phase_t           ph;
        logic [OFF_W-1:0] off;
        logic [ROW_W-1:0] jn;
    } pos_t;

    typedef struct packed {
        logic signed [31:0] joint_angle;
        logic [31:0]        start_reload;
        logic [31:0]        target_reload;
    } row_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [ROW_W-1:0] row;
        row_t             data;
    } row_wr_t;

    typedef struct packed {
        logic        valid;
        logic        accepted;
        logic        bank;
        logic [31:0] duration;
    } term_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_DIG0) && (c <= CH_DIG9);
    endfunction

    // Pattern element at a given place: MOVE, blank, then per joint
    // "J d _ n _ SA d _ n _ TA d _ n _", then "T n".
    function automatic elem_t pat_el(phase_t ph, logic [OFF_W-1:0] off,
                                     logic [ROW_W-1:0] jn);
        elem_t      e;
        logic [7:0] dig;
        dig    = CH_DIG1 + 8'(jn);
        e.kind = EK_WS;
        e.lit  = CH_NUL;
        case (ph)
            PH_HEAD:
            begin
                case (off)
                    5'd0:    begin e.kind = EK_LIT; e.lit = CH_M; end
                    5'd1:    begin e.kind = EK_LIT; e.lit = CH_O; end
                    5'd2:    begin e.kind = EK_LIT; e.lit = CH_V; end
                    5'd3:    begin e.kind = EK_LIT; e.lit = CH_E; end
                    default: e.kind = EK_WS;
                endcase
            end
            PH_JOINT:
            begin
                case (off)
                    5'd0:                 begin e.kind = EK_LIT; e.lit = CH_J; end
                    5'd1, 5'd7, 5'd13:    begin e.kind = EK_LIT; e.lit = dig; end
                    5'd3, 5'd9, 5'd15:    e.kind = EK_NUM;
                    5'd5:                 begin e.kind = EK_LIT; e.lit = CH_S; end
                    5'd6, 5'd12:          begin e.kind = EK_LIT; e.lit = CH_A; end
                    5'd11:                begin e.kind = EK_LIT; e.lit = CH_T; end
                    default:              e.kind = EK_WS;
                endcase
            end
            PH_TAIL:
            begin
                if (off == 5'd0)
                begin
                    e.kind = EK_LIT;
                    e.lit  = CH_T;
                end
                else
                begin
                    e.kind = EK_NUM;
                end
            end
            default:
            begin
                e.kind = EK_WS;
            end
        endcase
        return e;
    endfunction

    // acc * 10 + digit, saturated at the magnitude of the most negative value.
    function automatic logic [31:0] add_digit(logic [31:0] acc, logic [7:0] c);
        logic [35:0] t;
        logic [7:0]  d;
        d = c - CH_DIG0;
        t = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + {32'd0, d[3:0]};
        if (t > {4'b0000, NUM_MAG_MAX})
            return NUM_MAG_MAX;
        else
            return t[31:0];
    endfunction

endpackage

// ===== src/cmdp_if.sv =====
// Valid/ready channel interfaces for the command byte input and the joint record
// output. Depends on nothing.
`timescale 1ns / 1ps

interface cmdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface cmdp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         record_index;
    logic signed [31:0] joint_angle;
    logic [31:0]        start_reload;
    logic [31:0]        target_reload;
    logic [31:0]        duration_ms;
    logic               accepted;
    logic               last_record;

    modport source (output valid, output record_index, output joint_angle,
                    output start_reload, output target_reload, output duration_ms,
                    output accepted, output last_record, input ready);
    modport sink   (input valid, input record_index, input joint_angle,
                    input start_reload, input target_reload, input duration_ms,
                    input accepted, input last_record, output ready);
endinterface

// ===== src/cmdp_parser.sv =====
// Character sequencer: walks the command pattern one byte per accepted cycle, builds
// numbers and hands finished joint rows and end-of-command events on. Uses cmdp_pkg.
`timescale 1ns / 1ps

module cmdp_parser
    import cmdp_pkg::*;
#(
    parameter int JOINT_COUNT = JOINT_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  ch,
    output row_wr_t     wr,
    output term_t       term
);

    localparam int NUM_FIELDS = 3 * JOINT_COUNT + 1;
    localparam int FW         = $clog2(NUM_FIELDS + 1);

    pos_t                pos_reg,    pos_next;
    logic [31:0]         acc_reg,    acc_next;
    logic                neg_reg,    neg_next;
    logic                dig_reg,    dig_next;
    logic                sgn_reg,    sgn_next;
    logic [FW-1:0]       fields_reg, fields_next;
    logic                failed_reg, failed_next;
    logic                bank_reg,   bank_next;
    logic signed [31:0]  angle_reg,  angle_next;
    logic [31:0]         start_reg,  start_next;
    logic [31:0]         dur_reg,    dur_next;

    logic                done;
    logic                commit;
    pos_t                commit_pos;
    logic [31:0]         commit_val;
    elem_t               el;

    function automatic pos_t advance(pos_t p);
        pos_t n;
        n     = p;
        n.off = p.off + OFF_W'(1);
        case (p.ph)
            PH_HEAD:
            begin
                if (p.off == HEAD_LAST_OFF)
                begin
                    n.ph  = PH_JOINT;
                    n.off = '0;
                    n.jn  = '0;
                end
            end
            PH_JOINT:
            begin
                if (p.off == JOINT_LAST_OFF)
                begin
                    n.off = '0;
                    if (p.jn == ROW_W'(JOINT_COUNT - 1))
                        n.ph = PH_TAIL;
                    else
                        n.jn = p.jn + ROW_W'(1);
                end
            end
            PH_TAIL:
            begin
                if (p.off == TAIL_LAST_OFF)
                begin
                    n.ph  = PH_END;
                    n.off = '0;
                end
            end
            default:
            begin
                n = p;
            end
        endcase
        return n;
    endfunction

    // Signed value of the number being built, clamped to the 32-bit range.
    function automatic logic [31:0] number_value(logic [31:0] a, logic n);
        if (n)
            return 32'd0 - a;
        else if (a > NUM_MAX_POS)
            return NUM_MAX_POS;
        else
            return a;
    endfunction

    always_comb
    begin
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        dig_next    = dig_reg;
        sgn_next    = sgn_reg;
        fields_next = fields_reg;
        failed_next = failed_reg;
        bank_next   = bank_reg;
        angle_next  = angle_reg;
        start_next  = start_reg;
        dur_next    = dur_reg;
        done        = 1'b0;
        commit      = 1'b0;
        commit_pos  = pos_reg;
        commit_val  = number_value(acc_reg, neg_reg);
        el          = pat_el(pos_reg.ph, pos_reg.off, pos_reg.jn);
        term        = '0;

        if (accept && (ch != CH_NUL))
        begin
            // A blank element or a finished number can pass the byte on, so at
            // most three elements look at one byte.
            for (int k = 0; k < 3; k++)
            begin
                if (!done)
                begin
                    if (failed_next || (pos_next.ph == PH_END))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        el = pat_el(pos_next.ph, pos_next.off, pos_next.jn);
                        case (el.kind)
                            EK_WS:
                            begin
                                if (is_ws(ch))
                                    done = 1'b1;
                                else
                                    pos_next = advance(pos_next);
                            end
                            EK_NUM:
                            begin
                                if (dig_next)
                                begin
                                    if (is_digit(ch))
                                    begin
                                        acc_next = add_digit(acc_next, ch);
                                        done     = 1'b1;
                                    end
                                    else
                                    begin
                                        commit      = 1'b1;
                                        commit_pos  = pos_next;
                                        commit_val  = number_value(acc_next, neg_next);
                                        acc_next    = '0;
                                        neg_next    = 1'b0;
                                        dig_next    = 1'b0;
                                        sgn_next    = 1'b0;
                                        fields_next = fields_next + FW'(1);
                                        pos_next    = advance(pos_next);
                                    end
                                end
                                else if (sgn_next)
                                begin
                                    if (is_digit(ch))
                                    begin
                                        acc_next = add_digit(acc_next, ch);
                                        dig_next = 1'b1;
                                    end
                                    else
                                    begin
                                        failed_next = 1'b1;
                                    end
                                    done = 1'b1;
                                end
                                else if (is_ws(ch))
                                begin
                                    done = 1'b1;
                                end
                                else if ((ch == CH_PLUS) || (ch == CH_MINUS))
                                begin
                                    sgn_next = 1'b1;
                                    neg_next = (ch == CH_MINUS);
                                    done     = 1'b1;
                                end
                                else if (is_digit(ch))
                                begin
                                    acc_next = add_digit(acc_next, ch);
                                    dig_next = 1'b1;
                                    done     = 1'b1;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                    done        = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (ch == el.lit)
                                    pos_next = advance(pos_next);
                                else
                                    failed_next = 1'b1;
                                done = 1'b1;
                            end
                        endcase
                    end
                end
            end
        end
        else if (accept)
        begin
            // End of text: a number still open is taken before the verdict.
            if (!failed_reg && (pos_reg.ph != PH_END) && (el.kind == EK_NUM) && dig_reg)
            begin
                commit      = 1'b1;
                fields_next = fields_reg + FW'(1);
            end
        end

        if (commit && (commit_pos.ph == PH_JOINT))
        begin
            if (commit_pos.off == OFF_ANGLE)
                angle_next = commit_val;
            if (commit_pos.off == OFF_START)
                start_next = commit_val;
        end
        if (commit && (commit_pos.ph == PH_TAIL))
            dur_next = commit_val;

        wr.en                 = commit && (commit_pos.ph == PH_JOINT) &&
                                (commit_pos.off == OFF_TARGET);
        wr.bank               = bank_reg;
        wr.row                = commit_pos.jn;
        wr.data.joint_angle   = angle_reg;
        wr.data.start_reload  = start_reg;
        wr.data.target_reload = commit_val;

        if (accept && (ch == CH_NUL))
        begin
            term.valid    = 1'b1;
            term.accepted = !failed_reg && (fields_next == FW'(NUM_FIELDS));
            term.bank     = bank_reg;
            term.duration = dur_next;
            pos_next      = '{ph: PH_HEAD, off: '0, jn: '0};
            acc_next      = '0;
            neg_next      = 1'b0;
            dig_next      = 1'b0;
            sgn_next      = 1'b0;
            fields_next   = '0;
            failed_next   = 1'b0;
            bank_next     = !bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '{ph: PH_HEAD, off: '0, jn: '0};
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            dig_reg    <= 1'b0;
            sgn_reg    <= 1'b0;
            fields_reg <= '0;
            failed_reg <= 1'b0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            dig_reg    <= dig_next;
            sgn_reg    <= sgn_next;
            fields_reg <= fields_next;
            failed_reg <= failed_next;
            bank_reg   <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        start_reg <= start_next;
        dur_reg   <= dur_next;
    end

endmodule

// ===== src/cmdp_store.sv =====
// Record store: banked joint row memory, record read-out sequencer and the
// output register. Uses cmdp_pkg and the cmdp_out_if interface.
`timescale 1ns / 1ps

module cmdp_store
    import cmdp_pkg::*;
#(
    parameter int JOINT_COUNT = JOINT_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  row_wr_t           wr,
    input  term_t             term,
    output logic              busy,
    cmdp_out_if.source        rec
);

    localparam int JW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int AW    = JW + 1;
    localparam int DEPTH = 2 ** AW;

    row_t               mem [DEPTH];
    row_t               rd_data_reg;

    logic               em_active_reg, em_active_next;
    logic [JW-1:0]      em_idx_reg,    em_idx_next;
    logic               em_bank_reg,   em_bank_next;
    logic               em_acc_reg,    em_acc_next;
    logic [31:0]        em_dur_reg,    em_dur_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [JW-1:0]      pend_idx_reg;
    logic               pend_acc_reg;
    logic               pend_last_reg;
    logic [31:0]        pend_dur_reg;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_idx_reg;
    logic signed [31:0] out_angle_reg;
    logic [31:0]        out_start_reg;
    logic [31:0]        out_target_reg;
    logic [31:0]        out_dur_reg;
    logic               out_acc_reg;
    logic               out_last_reg;

    logic               issue;
    logic               issue_last;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;

    assign waddr = {wr.bank, wr.row[JW-1:0]};
    assign raddr = {em_bank_reg, em_idx_reg};
    assign busy  = em_active_reg || pend_valid_reg;

    // A read goes out only when the output register will be free as it lands.
    assign issue      = em_active_reg && !pend_valid_reg && (!out_valid_reg || rec.ready);
    assign issue_last = !em_acc_reg || (em_idx_reg == JW'(JOINT_COUNT - 1));

    always_comb
    begin
        em_active_next  = em_active_reg;
        em_idx_next     = em_idx_reg;
        em_bank_next    = em_bank_reg;
        em_acc_next     = em_acc_reg;
        em_dur_next     = em_dur_reg;
        pend_valid_next = issue;
        out_valid_next  = out_valid_reg && !rec.ready;

        if (term.valid)
        begin
            em_active_next = 1'b1;
            em_idx_next    = '0;
            em_bank_next   = term.bank;
            em_acc_next    = term.accepted;
            em_dur_next    = term.duration;
        end
        else if (issue)
        begin
            em_active_next = !issue_last;
            em_idx_next    = em_idx_reg + JW'(1);
        end

        if (pend_valid_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_active_reg  <= 1'b0;
            em_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            em_active_reg  <= em_active_next;
            em_idx_reg     <= em_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_bank_reg <= em_bank_next;
        em_acc_reg  <= em_acc_next;
        em_dur_reg  <= em_dur_next;
        if (issue)
        begin
            pend_idx_reg  <= em_idx_reg;
            pend_acc_reg  <= em_acc_reg;
            pend_last_reg <= issue_last;
            pend_dur_reg  <= em_dur_reg;
        end
        if (pend_valid_reg)
        begin
            out_idx_reg    <= pend_acc_reg ? 3'(pend_idx_reg) : 3'd0;
            out_angle_reg  <= pend_acc_reg ? rd_data_reg.joint_angle : 32'sd0;
            out_start_reg  <= pend_acc_reg ? rd_data_reg.start_reload : 32'd0;
            out_target_reg <= pend_acc_reg ? rd_data_reg.target_reload : 32'd0;
            out_dur_reg    <= pend_acc_reg ? pend_dur_reg : 32'd0;
            out_acc_reg    <= pend_acc_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[waddr] <= wr.data;
        if (issue)
            rd_data_reg <= mem[raddr];
    end

    assign rec.valid         = out_valid_reg;
    assign rec.record_index  = out_idx_reg;
    assign rec.joint_angle   = out_angle_reg;
    assign rec.start_reload  = out_start_reg;
    assign rec.target_reload = out_target_reg;
    assign rec.duration_ms   = out_dur_reg;
    assign rec.accepted      = out_acc_reg;
    assign rec.last_record   = out_last_reg;

endmodule

// ===== src/motion_command_text_parser_top.sv =====
// Motion command text parser, top level: joins the character sequencer and the
// record store. Uses cmdp_pkg, cmdp_if, cmdp_parser and cmdp_store.
`timescale 1ns / 1ps

// The block reads a motion command as a stream of bytes, one word per cycle, and
// matches it against "MOVE J1 n SA1 n TA1 n ... Jk n SAk n TAk n Tn" with scanf
// rules, where k is JOINT_COUNT. A zero byte ends the text. If every number was
// taken, the block then sends k joint records (angle, start and target reload
// words, and the common duration), otherwise one reject record with all fields
// zero and last_record set. Text after the last number is ignored. Every nonzero
// byte is taken as soon as it is offered, with no gaps, also while records of the
// previous command are still being read out. Parsed joint values go into a
// memory of two banks of rows (one bank per command in flight, one 96-bit row
// per joint), written once when a joint's target value is complete. The zero byte
// that ends a command waits (ready low) until the last record read of the previous
// command has been issued and its data has moved on to the output register;
// nothing else stalls the input. Records are read through the single memory read
// port; a new read is issued only after the previous one has left the pending
// stage and when the output register will be free. Whitespace is space, tab, LF,
// VT, FF and CR. Numbers saturate to the signed 32-bit range.

module motion_command_text_parser_top
    import cmdp_pkg::*;
#(
    parameter int JOINT_COUNT = JOINT_COUNT_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    cmdp_in_if.sink       cmd,
    cmdp_out_if.source    rec
);

    row_wr_t wr;
    term_t   term;
    logic    busy;
    logic    accept;

    // Only the terminating zero byte waits for the read-out of the prior command.
    assign cmd.ready = !busy || (cmd.ch != CH_NUL);
    assign accept    = cmd.valid && cmd.ready;

    cmdp_parser #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (cmd.ch),
        .wr     (wr),
        .term   (term)
    );

    cmdp_store #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .term  (term),
        .busy  (busy),
        .rec   (rec)
    );

endmodule

// ===== src/cmdp_checker.sv =====
// Port-level checks for the motion command text parser, bound to the top level.
// Uses cmdp_pkg.
`timescale 1ns / 1ps

module cmdp_checker
    import cmdp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_ch,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  record_index,
    input logic [31:0] joint_angle,
    input logic [31:0] start_reload,
    input logic [31:0] target_reload,
    input logic [31:0] duration_ms,
    input logic        accepted,
    input logic        last_record
);

    // Only the end-of-text byte is ever held back.
    a_stall_only_terminator: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> in_ch == CH_NUL)
        else $error("input stalled on a byte other than the terminator");

    a_reject_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> last_record && (record_index == 3'd0))
        else $error("reject record is not a single first and last record");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> (joint_angle == 32'd0) && (start_reload == 32'd0) &&
            (target_reload == 32'd0) && (duration_ms == 32'd0))
        else $error("reject record carries nonzero fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_index) &&
            $stable(joint_angle) && $stable(last_record))
        else $error("stalled record changed");

endmodule

bind motion_command_text_parser_top cmdp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (cmd.valid),
    .in_ready      (cmd.ready),
    .in_ch         (cmd.ch),
    .out_valid     (rec.valid),
    .out_ready     (rec.ready),
    .record_index  (rec.record_index),
    .joint_angle   (rec.joint_angle),
    .start_reload  (rec.start_reload),
    .target_reload (rec.target_reload),
    .duration_ms   (rec.duration_ms),
    .accepted      (rec.accepted),
    .last_record   (rec.last_record)
);

// ===== bench/testbench.sv =====
// Self-checking bench for motion_command_text_parser_top: feeds command text one
// byte per word and checks every joint or reject record against a built-in parser.
// Depends on cmdp_pkg, cmdp_if and the RTL under src.
`timescale 1ns / 1ps

module testbench;
    import cmdp_pkg::*;

    // Geometry of the command pattern for the default joint count.
    localparam int JOINTS     = JOINT_COUNT_DEF;
    localparam int NFIELDS    = 3 * JOINTS + 1;
    localparam int LAYOUT_LEN = 5 + 17 * JOINTS + 2;

    // Run control.  After the last expected record, the settle wait gives room
    // to catch anything extra.
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int PRINT_LIMIT   = 150;
    localparam int EXTREME_COUNT = 19;

    // One output record as the block should present it.
    typedef struct packed {
        logic [2:0]         record_index;
        logic signed [31:0] joint_angle;
        logic [31:0]        start_reload;
        logic [31:0]        target_reload;
        logic [31:0]        duration_ms;
        logic               accepted;
        logic               last_record;
    } joint_record_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cmdp_in_if  cmd_bus ();
    cmdp_out_if rec_bus ();

    motion_command_text_parser_top #(
        .JOINT_COUNT (JOINTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rec   (rec_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The pattern the parser walks through, one element per entry: a literal
    // character, a blank (any run of whitespace) or a decimal number.
    elem_kind_t layout_kind [LAYOUT_LEN];
    logic [7:0] layout_char [LAYOUT_LEN];
    int         layout_fill = 0;

    // Parse state of the command in progress.
    int          scan_pos;
    logic [31:0] num_mag;
    logic        num_neg;
    logic        num_has_digit;
    logic        num_has_sign;
    int          fields_done;
    logic        cmd_broken;
    logic [31:0] field_value [NFIELDS];

    // Records still owed by the block, oldest first.
    joint_record_t record_q [$];
    int            records_predicted = 0;

    int   mismatch_count = 0;
    int   stall_cycles   = 0;
    int   tx_idle_pct    = 35;
    int   rx_idle_pct    = 71;
    logic hold_request   = 1'b0;

    // Number texts that the command builder places into the pattern.
    string field_text [NFIELDS];

    // Saturation corners, sign forms, leading zeros and long digit runs.
    string extreme_text [EXTREME_COUNT] = '{
        "2147483647", "-2147483648", "0", "+0", "-0", "4294967295",
        "99999999999999999999", "-99999999999", "0000000123", "-2147483649",
        "+2147483648", "1", "9", "-1", "+7", "00", "2147483646",
        "-2147483647", "4294967296"
    };

    //------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------

    function automatic void lay_elem(elem_kind_t kind, logic [7:0] c);
        layout_kind[layout_fill] = kind;
        layout_char[layout_fill] = c;
        layout_fill++;
    endfunction

    function automatic logic is_blank_char(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit_char(logic [7:0] c);
        return (c >= CH_DIG0) && (c <= CH_DIG9);
    endfunction

    function automatic void clear_scan();
        scan_pos      = 0;
        num_mag       = '0;
        num_neg       = 1'b0;
        num_has_digit = 1'b0;
        num_has_sign  = 1'b0;
        fields_done   = 0;
        cmd_broken    = 1'b0;
    endfunction

    // Magnitude grows by one decimal digit and sticks at 2^31, which is the
    // largest magnitude that a negative number can still use.
    function automatic void take_digit(logic [7:0] c);
        logic [63:0] grown;
        grown = 64'(num_mag) * 64'd10 + 64'(c - CH_DIG0);
        num_mag = (grown > 64'(NUM_MAG_MAX)) ? NUM_MAG_MAX : grown[31:0];
        num_has_digit = 1'b1;
    endfunction

    function automatic void store_number();
        logic [31:0] value;
        if (num_neg)
            value = 32'd0 - num_mag;
        else if (num_mag > NUM_MAX_POS)
            value = NUM_MAX_POS;
        else
            value = num_mag;
        if (fields_done < NFIELDS)
            field_value[fields_done] = value;
        fields_done++;
        num_mag       = '0;
        num_neg       = 1'b0;
        num_has_digit = 1'b0;
        num_has_sign  = 1'b0;
        scan_pos++;
    endfunction

    // Advance the pattern by one nonzero byte.  A blank that the byte does not
    // continue and a number that the byte ends both hand the same byte on to
    // the next element.
    function automatic void scan_char(logic [7:0] c);
        logic again;
        again = 1'b1;
        while (again && !cmd_broken && (scan_pos < LAYOUT_LEN))
        begin
            again = 1'b0;
            case (layout_kind[scan_pos])
                EK_WS:
                begin
                    if (!is_blank_char(c))
                    begin
                        scan_pos++;
                        again = 1'b1;
                    end
                end
                EK_NUM:
                begin
                    if (num_has_digit)
                    begin
                        if (is_digit_char(c))
                            take_digit(c);
                        else
                        begin
                            store_number();
                            again = 1'b1;
                        end
                    end
                    else if (num_has_sign)
                    begin
                        if (is_digit_char(c))
                            take_digit(c);
                        else
                            cmd_broken = 1'b1;
                    end
                    else if (!is_blank_char(c))
                    begin
                        if ((c == CH_PLUS) || (c == CH_MINUS))
                        begin
                            num_has_sign = 1'b1;
                            num_neg      = (c == CH_MINUS);
                        end
                        else if (is_digit_char(c))
                            take_digit(c);
                        else
                            cmd_broken = 1'b1;
                    end
                end
                default:
                begin
                    if (c == layout_char[scan_pos])
                        scan_pos++;
                    else
                        cmd_broken = 1'b1;
                end
            endcase
        end
    endfunction

    // The zero byte closes the command: a number still open is taken, then
    // either one record per joint or a single reject record is owed.
    function automatic void end_command();
        joint_record_t rec;
        if (!cmd_broken && (scan_pos < LAYOUT_LEN) &&
            (layout_kind[scan_pos] == EK_NUM) && num_has_digit)
            store_number();
        if (!cmd_broken && (fields_done == NFIELDS))
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                rec.record_index  = 3'(j);
                rec.joint_angle   = field_value[3 * j];
                rec.start_reload  = field_value[3 * j + 1];
                rec.target_reload = field_value[3 * j + 2];
                rec.duration_ms   = field_value[NFIELDS - 1];
                rec.accepted      = 1'b1;
                rec.last_record   = (j == JOINTS - 1);
                record_q.push_back(rec);
                records_predicted++;
            end
        end
        else
        begin
            rec             = '0;
            rec.last_record = 1'b1;
            record_q.push_back(rec);
            records_predicted++;
        end
        clear_scan();
    endfunction

    //------------------------------------------------------------------------
    // Command text generation
    //------------------------------------------------------------------------

    // spacing 0 leaves every blank empty, 1 puts a single space, 2 puts a
    // random run of any whitespace character, possibly empty.
    function automatic string random_blank(int spacing);
        string      run;
        logic [7:0] c;
        run = "";
        if (spacing == 1)
            run = " ";
        else if (spacing == 2)
        begin
            repeat ($urandom_range(3))
            begin
                c = ($urandom_range(5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(4));
                run = {run, $sformatf("%c", c)};
            end
        end
        return run;
    endfunction

    function automatic string command_text(int spacing);
        string text;
        string d;
        text = {"MOVE", random_blank(spacing)};
        for (int j = 0; j < JOINTS; j++)
        begin
            d = $sformatf("%0d", j + 1);
            text = {text, "J", d, random_blank(spacing), field_text[3 * j],
                    random_blank(spacing)};
            text = {text, "SA", d, random_blank(spacing), field_text[3 * j + 1],
                    random_blank(spacing)};
            text = {text, "TA", d, random_blank(spacing), field_text[3 * j + 2],
                    random_blank(spacing)};
        end
        return {text, "T", field_text[NFIELDS - 1]};
    endfunction

    function automatic string random_number_text();
        string sign_txt;
        string digits;
        case ($urandom_range(3))
            0:       sign_txt = "+";
            1:       sign_txt = "-";
            default: sign_txt = "";
        endcase
        digits = "";
        case ($urandom_range(9))
            0, 1, 2, 3: digits = $sformatf("%0d", $urandom_range(999));
            4, 5:       digits = $sformatf("%0d", $urandom);
            6:          digits = $sformatf("%0d", $urandom_range(32'h8000_0010, 32'h7FFF_FFF0));
            7:
            begin
                repeat ($urandom_range(24, 10))
                    digits = {digits, $sformatf("%0d", $urandom_range(9))};
            end
            8:          digits = ($urandom_range(1) == 1) ? "2147483648" : "2147483647";
            default:    digits = $sformatf("000%0d", $urandom_range(99));
        endcase
        return {sign_txt, digits};
    endfunction

    function automatic string random_noise(int len);
        string text;
        text = "";
        repeat (len)
            text = {text, $sformatf("%c", 8'($urandom_range(255, 1)))};
        return text;
    endfunction

    function automatic void fill_small_fields();
        foreach (field_text[i])
            field_text[i] = $sformatf("%0d", $urandom_range(99));
    endfunction

    //------------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------------

    // Offer one byte, with random idle cycles ahead of it, and hold it until
    // the block takes the word.  The predictor sees each byte as it is taken.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.ch    <= 8'($urandom);
            @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.ch    <= c;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        if (c == CH_NUL)
            end_command();
        else
            scan_char(c);
    endtask

    task automatic send_command(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text.getc(i));
        send_char(CH_NUL);
    endtask

    // The sender goes quiet until every owed record has been taken.
    task automatic wait_for_records();
        cmd_bus.valid <= 1'b0;
        while (record_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Accepted commands built from the saturation corners, first packed with
    // no whitespace at all, then with single spaces, then with random runs.
    task automatic test_number_extremes();
        for (int pass = 0; pass < 3; pass++)
        begin
            foreach (field_text[i])
                field_text[i] = extreme_text[(i + 7 * pass) % EXTREME_COUNT];
            send_command(command_text(pass));
        end
    endtask

    // Each of these must end in exactly one reject record.
    task automatic test_reject_cases();
        string base;
        send_command("");
        fill_small_fields();
        base = command_text(1);
        send_command({"MOVX", base.substr(4, base.len() - 1)});
        send_command("move J1 1");
        send_command("MOVE J2 1 SA2 1");
        send_command("MOVE J1 x");
        send_command("MOVE J1 -+5");
        send_command("MOVE J1 5");
        send_command(base.substr(0, base.len() / 2));
        // A sign with no digit after it, right before the zero byte or a blank.
        field_text[NFIELDS - 1] = "-";
        send_command(command_text(1));
        field_text[NFIELDS - 1] = "+ ";
        send_command(command_text(0));
        // The final number never starts.
        field_text[NFIELDS - 1] = "   ";
        send_command(command_text(1));
    endtask

    // Anything after the final number is ignored, including high-bit bytes
    // and text that looks like the start of another command.
    task automatic test_trailing_text();
        fill_small_fields();
        send_command({command_text(1), " trailing 42 -x", $sformatf("%c%c", 8'hFF, 8'h80)});
        field_text[NFIELDS - 1] = "77";
        send_command({command_text(0), "MOVE J1 3"});
    endtask

    // The receiver stops for a long stretch while commands keep coming, so the
    // record store fills and the block has to hold back a zero byte.
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (3)
        begin
            fill_small_fields();
            send_command(command_text(0));
        end
        wait_for_records();
    endtask

    // Commands separated by a full drain of the output side.
    task automatic test_drain_pause();
        repeat (2)
        begin
            foreach (field_text[i])
                field_text[i] = random_number_text();
            send_command(command_text(2));
            wait_for_records();
        end
    endtask

    // Mostly well-formed commands with random numbers and spacing; the rest
    // carry trailing junk, are cut short, have one byte corrupted, or are
    // plain noise.
    task automatic test_random_traffic(input int record_goal);
        string text;
        int    pick;
        int    goal_end;
        goal_end = records_predicted + record_goal;
        while (records_predicted < goal_end)
        begin
            foreach (field_text[i])
                field_text[i] = random_number_text();
            text = command_text($urandom_range(2));
            pick = $urandom_range(99);
            if (pick < 15)
                text = {text, random_blank(2), random_noise($urandom_range(12, 1))};
            else if (pick < 27)
                text = text.substr(0, $urandom_range(text.len() - 2));
            else if (pick < 37)
                text.putc($urandom_range(text.len() - 1), 8'($urandom_range(255, 1)));
            else if (pick < 45)
                text = random_noise($urandom_range(40, 1));
            send_command(text);
        end
    endtask

    //------------------------------------------------------------------------
    // Output side
    //------------------------------------------------------------------------

    // Receiver readiness.  A pending hold request turns into a long stretch
    // of low ready, counted here; otherwise ready follows the idle rate.
    initial
    begin
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    rec_bus.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rec_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge clk);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    // Every record taken is compared field by field with the oldest owed one.
    always @(posedge clk)
    begin : check_records
        joint_record_t want;
        if (rst_n && rec_bus.valid && rec_bus.ready)
        begin
            if (record_q.size() == 0)
                report_mismatch("record with none owed", 32'(rec_bus.record_index), '0);
            else
            begin
                want = record_q.pop_front();
                if (rec_bus.record_index !== want.record_index)
                    report_mismatch("record_index", 32'(rec_bus.record_index),
                                    32'(want.record_index));
                if (rec_bus.joint_angle !== want.joint_angle)
                    report_mismatch("joint_angle", rec_bus.joint_angle, want.joint_angle);
                if (rec_bus.start_reload !== want.start_reload)
                    report_mismatch("start_reload", rec_bus.start_reload, want.start_reload);
                if (rec_bus.target_reload !== want.target_reload)
                    report_mismatch("target_reload", rec_bus.target_reload,
                                    want.target_reload);
                if (rec_bus.duration_ms !== want.duration_ms)
                    report_mismatch("duration_ms", rec_bus.duration_ms, want.duration_ms);
                if (rec_bus.accepted !== want.accepted)
                    report_mismatch("accepted", 32'(rec_bus.accepted), 32'(want.accepted));
                if (rec_bus.last_record !== want.last_record)
                    report_mismatch("last_record", 32'(rec_bus.last_record),
                                    32'(want.last_record));
            end
        end
    end

    // Any word moving on either side counts as progress; a long run of
    // cycles without one means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (rec_bus.valid && rec_bus.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    //------------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------------

    initial
    begin
        // Pattern: MOVE, blank, then per joint "J d _ n _ SA d _ n _ TA d _ n _",
        // and finally "T n".
        lay_elem(EK_LIT, CH_M);
        lay_elem(EK_LIT, CH_O);
        lay_elem(EK_LIT, CH_V);
        lay_elem(EK_LIT, CH_E);
        lay_elem(EK_WS, CH_NUL);
        for (int j = 0; j < JOINTS; j++)
        begin
            lay_elem(EK_LIT, CH_J);
            lay_elem(EK_LIT, CH_DIG1 + 8'(j));
            lay_elem(EK_WS, CH_NUL);
            lay_elem(EK_NUM, CH_NUL);
            lay_elem(EK_WS, CH_NUL);
            lay_elem(EK_LIT, CH_S);
            lay_elem(EK_LIT, CH_A);
            lay_elem(EK_LIT, CH_DIG1 + 8'(j));
            lay_elem(EK_WS, CH_NUL);
            lay_elem(EK_NUM, CH_NUL);
            lay_elem(EK_WS, CH_NUL);
            lay_elem(EK_LIT, CH_T);
            lay_elem(EK_LIT, CH_A);
            lay_elem(EK_LIT, CH_DIG1 + 8'(j));
            lay_elem(EK_WS, CH_NUL);
            lay_elem(EK_NUM, CH_NUL);
            lay_elem(EK_WS, CH_NUL);
        end
        lay_elem(EK_LIT, CH_T);
        lay_elem(EK_NUM, CH_NUL);
        clear_scan();

        cmd_bus.valid <= 1'b0;
        cmd_bus.ch    <= CH_NUL;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slow sender, slower receiver.
        tx_idle_pct = 35;
        rx_idle_pct = 71;
        test_number_extremes();
        test_reject_cases();
        test_trailing_text();
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic(24);
        wait_for_records();

        // Roles swapped: the receiver now waits on a sluggish sender.
        tx_idle_pct = 71;
        rx_idle_pct = 35;
        test_random_traffic(24);
        wait_for_records();

        // Both sides at full rate.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(24);
        wait_for_records();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
